// ===== sv/grcm_pkg.sv =====
// shared types and constants for the genetic roulette breeding block
`timescale 1ns / 1ps
package grcm_pkg;

  // population and field sizes
  localparam int POP      = 32;
  localparam int IDX_W    = 5;
  localparam int CNT_W    = IDX_W + 1;
  localparam int GENE_W   = 64;
  localparam int BIT_W    = 6;
  localparam int LEN_W    = 7;
  localparam int FIT_W    = 16;
  localparam int TOTAL_W  = 21;
  localparam int FRAC_W   = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // register reset values
  localparam logic [LEN_W-1:0] RST_CHROM_LENGTH   = 7'd64;
  localparam logic [15:0]      RST_CROSSOVER_RATE = 16'd45875;
  localparam logic [15:0]      RST_MUTATION_RATE  = 16'd66;
  localparam logic [15:0]      RST_LFSR_SEED      = 16'd44257;

  // galois feedback taps of the mutation generator
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  // operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_BREED = 1'b1;

  // result status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_PICK = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHROM_LENGTH   = 2'd0,
    CFG_CROSSOVER_RATE = 2'd1,
    CFG_MUTATION_RATE  = 2'd2,
    CFG_LFSR_SEED      = 2'd3
  } cfg_idx_t;

  // control of the mutation generator
  typedef struct packed {
    logic        load;
    logic [15:0] seed;
    logic        step;
  } lfsr_ctl_t;

endpackage

// ===== sv/grcm_mutator.sv =====
// mutation random generator: 16-bit galois lfsr and per-bit flip decision
`timescale 1ns / 1ps
module grcm_mutator (
  input  logic                clk,
  input  logic                rst,
  input  grcm_pkg::lfsr_ctl_t ctl,
  input  logic [15:0]         mutation_rate,
  output logic                flip
);

  logic [15:0] lfsr;
  logic [15:0] lfsr_next;

  // one galois step: shift right, fold taps in when a one falls out
  always_comb begin
    lfsr_next = {1'b0, lfsr[15:1]};
    if (lfsr[0]) begin
      lfsr_next = lfsr_next ^ grcm_pkg::LFSR_TAPS;
    end
  end

  // flip decision uses the freshly stepped value
  assign flip = (lfsr_next < mutation_rate);

  // generator state, reseeded on a seed write, zero seed loads as one
  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= grcm_pkg::RST_LFSR_SEED;
    end else if (ctl.load) begin
      lfsr <= (ctl.seed == 16'd0) ? 16'd1 : ctl.seed;
    end else if (ctl.step) begin
      lfsr <= lfsr_next;
    end
  end

endmodule

// ===== sv/genetic_roulette_crossover_mutation.sv =====
// top level: population store, roulette selection, crossover and mutation sequencer
// load: a fitness read state, then a store write and total update state
// breed: per parent a multiply state plus a roulette walk over the slots up to the chosen one,
//   then gene reads and crossover, then a mutation loop over L bits per child (L = genes in use)
// each result is held one cycle on result_valid, child two follows the bit loop of child one
// reset (synchronous): fitness valid bits, fitness total, registers to defaults, lfsr to seed
`timescale 1ns / 1ps
module genetic_roulette_crossover_mutation (
  input  logic                                  clk,
  input  logic                                  rst,
  // command channel
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  opcode,
  input  logic [grcm_pkg::IDX_W-1:0]            member_index,
  input  logic [grcm_pkg::GENE_W-1:0]           member_genes,
  input  logic [grcm_pkg::FIT_W-1:0]            member_fitness,
  input  logic [grcm_pkg::FRAC_W-1:0]           mum_slice,
  input  logic [grcm_pkg::FRAC_W-1:0]           dad_slice,
  input  logic [grcm_pkg::FRAC_W-1:0]           cross_draw,
  input  logic [grcm_pkg::BIT_W-1:0]            cross_point,
  // configuration channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [grcm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [grcm_pkg::CFG_W-1:0]            cfg_data,
  // results
  output logic                                  result_valid,
  output logic [grcm_pkg::GENE_W-1:0]           child_genes,
  output logic                                  child_number,
  output logic                                  status,
  output logic                                  last
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_LD_RD = 11'b00000000010,
    S_LD_WR = 11'b00000000100,
    S_MUL   = 11'b00000001000,
    S_WALK  = 11'b00000010000,
    S_G1    = 11'b00000100000,
    S_G2    = 11'b00001000000,
    S_G3    = 11'b00010000000,
    S_CROSS = 11'b00100000000,
    S_MUT   = 11'b01000000000,
    S_SPARE = 11'b10000000000
  } state_t;

  state_t state;

  // configuration registers
  logic [grcm_pkg::LEN_W-1:0] chrom_length;
  logic [15:0]                crossover_rate;
  logic [15:0]                mutation_rate;

  // captured command fields
  logic [grcm_pkg::IDX_W-1:0]        index_q;
  logic [grcm_pkg::GENE_W-1:0]       genes_q;
  logic [grcm_pkg::FIT_W-1:0]        fitness_q;
  logic [grcm_pkg::FRAC_W-1:0]       mum_slice_q;
  logic [grcm_pkg::FRAC_W-1:0]       dad_slice_q;
  logic [grcm_pkg::FRAC_W-1:0]       draw_q;
  logic [grcm_pkg::BIT_W-1:0]        point_q;

  // fitness memory with valid bits, gene memory
  logic [grcm_pkg::FIT_W-1:0]  fit_mem   [grcm_pkg::POP];
  logic [grcm_pkg::POP-1:0]    fit_valid;
  logic [grcm_pkg::FIT_W-1:0]  fit_q;
  logic                        fit_vq;
  logic [grcm_pkg::IDX_W-1:0]  fit_raddr;
  logic                        fit_we;
  logic [grcm_pkg::GENE_W-1:0] gene_mem  [grcm_pkg::POP];
  logic [grcm_pkg::GENE_W-1:0] gene_q;
  logic [grcm_pkg::IDX_W-1:0]  gene_raddr;
  logic [grcm_pkg::FIT_W-1:0]  fit_val;

  logic [grcm_pkg::TOTAL_W-1:0] fitness_total;

  // roulette walk
  logic                          pick;
  logic [grcm_pkg::CNT_W-1:0]    walk_cnt;
  logic                          proc_valid;
  logic [grcm_pkg::IDX_W-1:0]    proc_idx;
  logic [grcm_pkg::TOTAL_W-1:0]  run;
  logic [grcm_pkg::TOTAL_W-1:0]  run_sum;
  logic [grcm_pkg::TOTAL_W-1:0]  slice;
  logic [grcm_pkg::FRAC_W+grcm_pkg::TOTAL_W-1:0] slice_prod;
  logic [grcm_pkg::IDX_W-1:0]    mum_idx;
  logic [grcm_pkg::IDX_W-1:0]    dad_idx;

  // chromosome datapath
  logic [grcm_pkg::LEN_W-1:0]  nlen;
  logic [grcm_pkg::LEN_W-1:0]  nlen_m1;
  logic [grcm_pkg::GENE_W-1:0] len_mask;
  logic [grcm_pkg::BIT_W-1:0]  cut;
  logic [grcm_pkg::GENE_W-1:0] lo_mask;
  logic [grcm_pkg::GENE_W-1:0] par_a;
  logic [grcm_pkg::GENE_W-1:0] par_b;
  logic [grcm_pkg::GENE_W-1:0] cross_c1;
  logic [grcm_pkg::GENE_W-1:0] cross_c2;
  logic [grcm_pkg::GENE_W-1:0] work;
  logic [grcm_pkg::GENE_W-1:0] work_flip;
  logic [grcm_pkg::GENE_W-1:0] second;
  logic [grcm_pkg::BIT_W-1:0]  bit_i;
  logic                        child;

  grcm_pkg::lfsr_ctl_t lfsr_ctl;
  logic                flip;

  logic cmd_accept;
  logic cfg_accept;

  assign busy       = (state != S_IDLE);
  assign cfg_ready  = ~busy;
  assign cmd_accept = start & ~busy;
  assign cfg_accept = cfg_valid & cfg_ready;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      chrom_length   <= grcm_pkg::RST_CHROM_LENGTH;
      crossover_rate <= grcm_pkg::RST_CROSSOVER_RATE;
      mutation_rate  <= grcm_pkg::RST_MUTATION_RATE;
    end else if (cfg_accept) begin
      unique case (grcm_pkg::cfg_idx_t'(cfg_index))
        grcm_pkg::CFG_CHROM_LENGTH:   chrom_length   <= cfg_data[grcm_pkg::LEN_W-1:0];
        grcm_pkg::CFG_CROSSOVER_RATE: crossover_rate <= cfg_data;
        grcm_pkg::CFG_MUTATION_RATE:  mutation_rate  <= cfg_data;
        grcm_pkg::CFG_LFSR_SEED:      ;
        default:                      ;
      endcase
    end
  end

  // mutation generator control: reseed on a seed write, step in the bit loop
  always_comb begin
    lfsr_ctl.load = cfg_accept && (grcm_pkg::cfg_idx_t'(cfg_index) == grcm_pkg::CFG_LFSR_SEED);
    lfsr_ctl.seed = cfg_data;
    lfsr_ctl.step = (state == S_MUT);
  end

  grcm_mutator u_mutator (
    .clk           (clk),
    .rst           (rst),
    .ctl           (lfsr_ctl),
    .mutation_rate (mutation_rate),
    .flip          (flip)
  );

  // in-use length, its mask and the clamped crossover cut
  always_comb begin
    if (chrom_length == '0) begin
      nlen = grcm_pkg::LEN_W'(1);
    end else if (chrom_length > grcm_pkg::LEN_W'(grcm_pkg::GENE_W)) begin
      nlen = grcm_pkg::LEN_W'(grcm_pkg::GENE_W);
    end else begin
      nlen = chrom_length;
    end
    nlen_m1  = nlen - grcm_pkg::LEN_W'(1);
    len_mask = nlen[grcm_pkg::BIT_W] ? '1 :
               ((grcm_pkg::GENE_W'(1) << nlen[grcm_pkg::BIT_W-1:0]) - grcm_pkg::GENE_W'(1));
    cut      = (point_q > nlen_m1[grcm_pkg::BIT_W-1:0]) ?
               nlen_m1[grcm_pkg::BIT_W-1:0] : point_q;
    lo_mask  = (grcm_pkg::GENE_W'(1) << cut) - grcm_pkg::GENE_W'(1);
  end

  // single point crossover, skipped on a high draw or equal parents
  always_comb begin
    if ((draw_q > crossover_rate) || (par_a == par_b)) begin
      cross_c1 = par_a;
      cross_c2 = par_b;
    end else begin
      cross_c1 = (par_a & lo_mask) | (par_b & ~lo_mask & len_mask);
      cross_c2 = (par_b & lo_mask) | (par_a & ~lo_mask & len_mask);
    end
  end

  // fitness memory read address and write enable
  assign fit_raddr = (state == S_LD_RD) ? index_q : walk_cnt[grcm_pkg::IDX_W-1:0];
  assign fit_we    = (state == S_LD_WR);
  assign fit_val   = fit_vq ? fit_q : '0;

  // fitness memory, registered read
  always_ff @(posedge clk) begin
    if (fit_we) begin
      fit_mem[index_q] <= fitness_q;
    end
    fit_q <= fit_mem[fit_raddr];
  end

  // fitness valid bits, an unwritten slot reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_valid <= '0;
      fit_vq    <= 1'b0;
    end else begin
      if (fit_we) begin
        fit_valid[index_q] <= 1'b1;
      end
      fit_vq <= fit_valid[fit_raddr];
    end
  end

  // gene memory, registered read
  assign gene_raddr = (state == S_G1) ? mum_idx : dad_idx;

  always_ff @(posedge clk) begin
    if (fit_we) begin
      gene_mem[index_q] <= genes_q;
    end
    gene_q <= gene_mem[gene_raddr];
  end

  // shared slice multiplier and walk adder
  assign slice_prod = (pick ? dad_slice_q : mum_slice_q) * fitness_total;
  assign run_sum    = run + grcm_pkg::TOTAL_W'(fit_val);
  assign work_flip  = work ^ ({{(grcm_pkg::GENE_W-1){1'b0}}, flip} << bit_i);

  // command capture
  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      index_q     <= member_index;
      genes_q     <= member_genes;
      fitness_q   <= member_fitness;
      mum_slice_q <= mum_slice;
      dad_slice_q <= dad_slice;
      draw_q      <= cross_draw;
      point_q     <= cross_point;
    end
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      fitness_total <= '0;
      result_valid  <= 1'b0;
      pick          <= 1'b0;
      proc_valid    <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_accept) begin
            pick  <= 1'b0;
            state <= (opcode == grcm_pkg::OP_BREED) ? S_MUL : S_LD_RD;
          end
        end
        S_LD_RD: begin
          state <= S_LD_WR;
        end
        S_LD_WR: begin
          fitness_total <= fitness_total - grcm_pkg::TOTAL_W'(fit_val)
                           + grcm_pkg::TOTAL_W'(fitness_q);
          state <= S_IDLE;
        end
        S_MUL: begin
          slice      <= slice_prod[grcm_pkg::FRAC_W +: grcm_pkg::TOTAL_W];
          walk_cnt   <= '0;
          run        <= '0;
          proc_valid <= 1'b0;
          state      <= S_WALK;
        end
        S_WALK: begin
          // issue one read a cycle, check the slot read the cycle before
          if (!walk_cnt[grcm_pkg::IDX_W]) begin
            walk_cnt <= walk_cnt + grcm_pkg::CNT_W'(1);
          end
          proc_valid <= ~walk_cnt[grcm_pkg::IDX_W];
          proc_idx   <= walk_cnt[grcm_pkg::IDX_W-1:0];
          if (proc_valid) begin
            run <= run_sum;
            if (run_sum > slice) begin
              if (!pick) begin
                mum_idx <= proc_idx;
                pick    <= 1'b1;
                state   <= S_MUL;
              end else begin
                dad_idx <= proc_idx;
                state   <= S_G1;
              end
            end else if (proc_idx == grcm_pkg::IDX_W'(grcm_pkg::POP - 1)) begin
              // no slot passed the slice: single failure result
              result_valid <= 1'b1;
              child_genes  <= '0;
              child_number <= 1'b0;
              status       <= grcm_pkg::STATUS_NO_PICK;
              last         <= 1'b1;
              state        <= S_IDLE;
            end
          end
        end
        S_G1: begin
          state <= S_G2;
        end
        S_G2: begin
          par_a <= gene_q & len_mask;
          state <= S_G3;
        end
        S_G3: begin
          par_b <= gene_q & len_mask;
          state <= S_CROSS;
        end
        S_CROSS: begin
          work   <= cross_c1;
          second <= cross_c2;
          bit_i  <= '0;
          child  <= 1'b0;
          state  <= S_MUT;
        end
        S_MUT: begin
          // one lfsr step per in-use bit, child one then child two
          if (bit_i == nlen_m1[grcm_pkg::BIT_W-1:0]) begin
            result_valid <= 1'b1;
            child_genes  <= work_flip;
            child_number <= child;
            status       <= grcm_pkg::STATUS_OK;
            last         <= child;
            bit_i        <= '0;
            if (!child) begin
              work  <= second;
              child <= 1'b1;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            work  <= work_flip;
            bit_i <= bit_i + grcm_pkg::BIT_W'(1);
          end
        end
        S_SPARE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // a failure result is a lone, empty, final transaction
  a_fail_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == grcm_pkg::STATUS_NO_PICK) |-> last && (child_genes == '0))
    else $error("failure result malformed");

  // a valid child is last exactly when it is the second one
  a_last_second: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == grcm_pkg::STATUS_OK) |-> (last == child_number))
    else $error("last flag does not match child number");

  // no gene bit above the in-use length is ever set
  a_len_mask: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((child_genes & ~len_mask) == '0))
    else $error("child has bits above chromosome length");

  // an accepted command makes the block busy on the next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    cmd_accept |=> busy)
    else $error("block not busy after accepted command");
`endif

endmodule

// ===== tb/genetic_roulette_crossover_mutation_tb.sv =====
// self-checking testbench for the genetic roulette breeding block
`timescale 1ns / 1ps
module genetic_roulette_crossover_mutation_tb;

  localparam int SETTLE_CYCLES = 250;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int PHASES        = 8;
  localparam int MIXED_ITEMS   = 120;

  // one command transaction
  typedef struct packed {
    logic                          opcode;
    logic [grcm_pkg::IDX_W-1:0]    member_index;
    logic [grcm_pkg::GENE_W-1:0]   member_genes;
    logic [grcm_pkg::FIT_W-1:0]    member_fitness;
    logic [grcm_pkg::FRAC_W-1:0]   mum_slice;
    logic [grcm_pkg::FRAC_W-1:0]   dad_slice;
    logic [grcm_pkg::FRAC_W-1:0]   cross_draw;
    logic [grcm_pkg::BIT_W-1:0]    cross_point;
  } command_t;

  // one result transaction
  typedef struct packed {
    logic [grcm_pkg::GENE_W-1:0] genes;
    logic                        number;
    logic                        status;
    logic                        last;
  } child_t;

  // population mirror, breeding predictor and child checker
  class brood_predictor;
    logic [grcm_pkg::GENE_W-1:0]  genes [grcm_pkg::POP];
    logic [grcm_pkg::FIT_W-1:0]   fitness [grcm_pkg::POP];
    logic [grcm_pkg::TOTAL_W-1:0] total;
    logic [15:0]                  lfsr;
    logic [grcm_pkg::LEN_W-1:0]   chrom_length;
    logic [15:0]                  crossover_rate;
    logic [15:0]                  mutation_rate;
    child_t                       expected_children [$];
    int                           errors;

    function new();
      foreach (genes[i]) begin
        genes[i] = '0;
        fitness[i] = '0;
      end
      total = '0;
      chrom_length = grcm_pkg::RST_CHROM_LENGTH;
      crossover_rate = grcm_pkg::RST_CROSSOVER_RATE;
      mutation_rate = grcm_pkg::RST_MUTATION_RATE;
      lfsr = grcm_pkg::RST_LFSR_SEED;
      errors = 0;
    endfunction

    function void write_reg(grcm_pkg::cfg_idx_t idx, logic [grcm_pkg::CFG_W-1:0] data);
      case (idx)
        grcm_pkg::CFG_CHROM_LENGTH:   chrom_length = data[grcm_pkg::LEN_W-1:0];
        grcm_pkg::CFG_CROSSOVER_RATE: crossover_rate = data;
        grcm_pkg::CFG_MUTATION_RATE:  mutation_rate = data;
        grcm_pkg::CFG_LFSR_SEED:      lfsr = (data == 16'd0) ? 16'd1 : data;
        default: ;
      endcase
    endfunction

    // append one expected child at the tail of the queue
    function void add_child(child_t ch);
      expected_children.insert(expected_children.size(), ch);
    endfunction

    // length register clamped to 1..GENE_W
    function int genes_in_use();
      int n;
      n = chrom_length;
      if (n < 1) n = 1;
      if (n > grcm_pkg::GENE_W) n = grcm_pkg::GENE_W;
      return n;
    endfunction

    function logic [grcm_pkg::GENE_W-1:0] low_bits(int n);
      if (n >= grcm_pkg::GENE_W) return '1;
      return (64'd1 << n) - 64'd1;
    endfunction

    // first slot whose running fitness sum exceeds the scaled slice
    function int pick_slot(logic [grcm_pkg::FRAC_W-1:0] frac);
      logic [36:0] slice;
      logic [36:0] run;
      slice = ({21'd0, frac} * {16'd0, total}) >> 16;
      run = '0;
      for (int i = 0; i < grcm_pkg::POP; i++) begin
        run = run + fitness[i];
        if (run > slice) return i;
      end
      return -1;
    endfunction

    // galois lfsr step per bit, flip when the new value is below the rate
    function logic [grcm_pkg::GENE_W-1:0] mutate(logic [grcm_pkg::GENE_W-1:0] g, int n);
      logic fb;
      for (int i = 0; i < n; i++) begin
        fb = lfsr[0];
        lfsr = lfsr >> 1;
        if (fb) lfsr = lfsr ^ grcm_pkg::LFSR_TAPS;
        if (lfsr < mutation_rate) g[i] = ~g[i];
      end
      return g;
    endfunction

    // update the mirror for an accepted command and queue its children
    function void note_command(command_t c);
      int                          n;
      int                          mum;
      int                          dad;
      int                          p;
      logic [grcm_pkg::GENE_W-1:0] m;
      logic [grcm_pkg::GENE_W-1:0] a;
      logic [grcm_pkg::GENE_W-1:0] b;
      logic [grcm_pkg::GENE_W-1:0] c1;
      logic [grcm_pkg::GENE_W-1:0] c2;
      logic [grcm_pkg::GENE_W-1:0] lo;
      n = genes_in_use();
      m = low_bits(n);
      if (c.opcode == grcm_pkg::OP_LOAD) begin
        total = total - fitness[c.member_index] + c.member_fitness;
        fitness[c.member_index] = c.member_fitness;
        genes[c.member_index] = c.member_genes;
        return;
      end
      mum = pick_slot(c.mum_slice);
      dad = pick_slot(c.dad_slice);
      if (mum < 0 || dad < 0) begin
        add_child('{'0, 1'b0, grcm_pkg::STATUS_NO_PICK, 1'b1});
        return;
      end
      a = genes[mum] & m;
      b = genes[dad] & m;
      if (c.cross_draw > crossover_rate || a == b) begin
        c1 = a;
        c2 = b;
      end else begin
        p = c.cross_point;
        if (p > n - 1) p = n - 1;
        lo = low_bits(p);
        c1 = (a & lo) | (b & ~lo & m);
        c2 = (b & lo) | (a & ~lo & m);
      end
      c1 = mutate(c1, n) & m;
      c2 = mutate(c2, n) & m;
      add_child('{c1, 1'b0, grcm_pkg::STATUS_OK, 1'b0});
      add_child('{c2, 1'b1, grcm_pkg::STATUS_OK, 1'b1});
    endfunction

    // compare one result with the oldest expected child
    function void check_child(child_t got);
      child_t want;
      if (expected_children.size() == 0) begin
        $error("unexpected result: child_genes %h child_number %0d status %0d last %0d",
               got.genes, got.number, got.status, got.last);
        errors++;
        return;
      end
      want = expected_children.pop_front();
      if (got.genes !== want.genes) begin
        $error("child_genes: expected %h, actual %h", want.genes, got.genes);
        errors++;
      end
      if (got.number !== want.number) begin
        $error("child_number: expected %0d, actual %0d", want.number, got.number);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           start = 1'b0;
  logic                           busy;
  logic                           opcode = grcm_pkg::OP_LOAD;
  logic [grcm_pkg::IDX_W-1:0]     member_index = '0;
  logic [grcm_pkg::GENE_W-1:0]    member_genes = '0;
  logic [grcm_pkg::FIT_W-1:0]     member_fitness = '0;
  logic [grcm_pkg::FRAC_W-1:0]    mum_slice = '0;
  logic [grcm_pkg::FRAC_W-1:0]    dad_slice = '0;
  logic [grcm_pkg::FRAC_W-1:0]    cross_draw = '0;
  logic [grcm_pkg::BIT_W-1:0]     cross_point = '0;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [grcm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [grcm_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                           result_valid;
  logic [grcm_pkg::GENE_W-1:0]    child_genes;
  logic                           child_number;
  logic                           status;
  logic                           last;

  brood_predictor brood = new();
  int             cycle_count = 0;

  genetic_roulette_crossover_mutation dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .member_index (member_index),
    .member_genes (member_genes),
    .member_fitness(member_fitness),
    .mum_slice    (mum_slice),
    .dad_slice    (dad_slice),
    .cross_draw   (cross_draw),
    .cross_point  (cross_point),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .child_genes  (child_genes),
    .child_number (child_number),
    .status       (status),
    .last         (last)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result monitor, one transaction per strobe
  always @(posedge clk) begin
    if (!rst && result_valid)
      brood.check_child('{child_genes, child_number, status, last});
  end

  function automatic command_t make_load(int idx, logic [grcm_pkg::GENE_W-1:0] g,
                                         logic [grcm_pkg::FIT_W-1:0] f);
    command_t c;
    c = '{grcm_pkg::OP_LOAD, grcm_pkg::IDX_W'(idx), g, f, 16'($urandom), 16'($urandom),
          16'($urandom), 6'($urandom_range(0, 63))};
    return c;
  endfunction

  function automatic command_t make_breed(logic [grcm_pkg::FRAC_W-1:0] mum,
                                          logic [grcm_pkg::FRAC_W-1:0] dad,
                                          logic [grcm_pkg::FRAC_W-1:0] draw, int point);
    command_t c;
    c = '{grcm_pkg::OP_BREED, grcm_pkg::IDX_W'($urandom_range(0, grcm_pkg::POP - 1)),
          {$urandom, $urandom}, 16'($urandom), mum, dad, draw, grcm_pkg::BIT_W'(point)};
    return c;
  endfunction

  // fitness with extra weight on zero and full scale
  function automatic logic [grcm_pkg::FIT_W-1:0] random_fitness();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [grcm_pkg::FRAC_W-1:0] random_slice();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly breeds on a loaded population, some member reloads
  function automatic command_t random_command();
    if ($urandom_range(0, 9) < 3)
      return make_load($urandom_range(0, grcm_pkg::POP - 1), {$urandom, $urandom},
                       random_fitness());
    return make_breed(random_slice(), random_slice(), 16'($urandom), $urandom_range(0, 63));
  endfunction

  // drive one command transaction, optional idle burst afterward
  task automatic send_command(input command_t c, input bit allow_gaps);
    start <= 1'b1;
    opcode <= c.opcode;
    member_index <= c.member_index;
    member_genes <= c.member_genes;
    member_fitness <= c.member_fitness;
    mum_slice <= c.mum_slice;
    dad_slice <= c.dad_slice;
    cross_draw <= c.cross_draw;
    cross_point <= c.cross_point;
    @(posedge clk);
    while (busy) @(posedge clk);
    brood.note_command(c);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // one register write transaction, valid left high for the next one
  task automatic write_register(input grcm_pkg::cfg_idx_t idx,
                                input logic [grcm_pkg::CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    brood.write_reg(idx, data);
  endtask

  task automatic configure(input logic [grcm_pkg::CFG_W-1:0] len,
                           input logic [grcm_pkg::CFG_W-1:0] xrate,
                           input logic [grcm_pkg::CFG_W-1:0] mrate,
                           input logic [grcm_pkg::CFG_W-1:0] seed);
    write_register(grcm_pkg::CFG_CHROM_LENGTH, len);
    write_register(grcm_pkg::CFG_CROSSOVER_RATE, xrate);
    write_register(grcm_pkg::CFG_MUTATION_RATE, mrate);
    write_register(grcm_pkg::CFG_LFSR_SEED, seed);
    cfg_valid <= 1'b0;
  endtask

  // wait for all children, then let trailing loads finish
  task automatic settle();
    while (brood.expected_children.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    bit gaps;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty population under reset settings: no parent
    send_command(make_breed(16'h0000, 16'hFFFF, 16'h0000, 0), 1'b0);
    start <= 1'b0;
    settle();

    // plain crossover, no mutation
    configure(16'd64, 16'h8000, 16'h0000, 16'h0001);
    send_command(make_load(0, '1, 16'hFFFF), 1'b0);
    send_command(make_load(31, '0, 16'hFFFF), 1'b0);
    send_command(make_load(5, 64'hA5A5_A5A5_A5A5_A5A5, 16'h0000), 1'b0);
    send_command(make_load(7, 64'h0123_4567_89AB_CDEF, 16'h0001), 1'b0);
    send_command(make_breed(16'h0000, 16'hFFFF, 16'h0000, 0), 1'b0);
    send_command(make_breed(16'h0000, 16'hFFFF, 16'h0000, 63), 1'b0);
    send_command(make_breed(16'h0000, 16'hFFFF, 16'h0000, 32), 1'b0);
    // draw equal to the rate still crosses, one above does not
    send_command(make_breed(16'h0000, 16'hFFFF, 16'h8000, 20), 1'b0);
    send_command(make_breed(16'h0000, 16'hFFFF, 16'h8001, 20), 1'b0);
    // same parent twice
    send_command(make_breed(16'h0000, 16'h0000, 16'h0000, 10), 1'b0);
    // overwrite a member, two slots now hold equal genes
    send_command(make_load(0, '0, 16'h1234), 1'b0);
    send_command(make_breed(16'h0000, 16'hFFFF, 16'h0000, 10), 1'b0);
    send_command(make_breed(16'h8000, 16'h4000, 16'hFFFF, 63), 1'b0);
    start <= 1'b0;
    settle();

    // zero length acts as one, zero seed loads as one, heavy mutation
    configure(16'd0, 16'h0000, 16'hFFFF, 16'h0000);
    send_command(make_breed(16'h0000, 16'hFFFF, 16'h0000, 63), 1'b0);
    send_command(make_breed(16'h1111, 16'hEEEE, 16'h0001, 5), 1'b0);
    start <= 1'b0;
    settle();

    // length above the maximum, full crossover rate
    configure(16'd127, 16'hFFFF, 16'h1000, 16'hFFFF);
    send_command(make_breed(16'h0000, 16'hFFFF, 16'hFFFF, 63), 1'b0);
    send_command(make_breed(16'h7FFF, 16'hFFFF, 16'h1234, 1), 1'b0);
    // empty the population again: no parent
    send_command(make_load(0, '0, 16'h0000), 1'b0);
    send_command(make_load(7, '0, 16'h0000), 1'b0);
    send_command(make_load(31, '0, 16'h0000), 1'b0);
    send_command(make_breed(16'h8000, 16'h0000, 16'h0000, 0), 1'b0);
    start <= 1'b0;

    // random phases over several register settings
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: configure(16'd64, 16'hFFFF, 16'h0000, 16'h0001);
        1: configure(16'd1, 16'd45875, 16'd66, 16'hACE1);
        2: configure(16'd127, 16'h0000, 16'hFFFF, 16'hFFFF);
        3: configure(16'd0, 16'h8000, 16'h0400, 16'h0000);
        default: configure(16'($urandom_range(1, 64)), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 2048)), 16'($urandom_range(1, 65535)));
      endcase
      gaps = (ph != 4) && (ph != PHASES - 1);
      // cleared population gives no-parent results
      if (ph == 3) begin
        for (int s = 0; s < grcm_pkg::POP; s++)
          send_command(make_load(s, {$urandom, $urandom}, '0), gaps);
        repeat (3) send_command(make_breed(random_slice(), random_slice(), 16'($urandom),
                                           $urandom_range(0, 63)), gaps);
      end
      // fresh population
      for (int s = 0; s < grcm_pkg::POP; s++)
        send_command(make_load(s, {$urandom, $urandom}, random_fitness()), gaps);
      repeat (MIXED_ITEMS) send_command(random_command(), gaps);
      start <= 1'b0;
    end

    settle();
    if (brood.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
sv/grcm_pkg.sv
sv/grcm_mutator.sv
sv/genetic_roulette_crossover_mutation.sv
tb/genetic_roulette_crossover_mutation_tb.sv
